// ----- rtl/core/block_id_bump_allocator_core_defines.svh -----
// Assertion macros for the block ID bump allocator core.
`ifndef BLOCK_ID_BUMP_ALLOCATOR_CORE_DEFINES_SVH
`define BLOCK_ID_BUMP_ALLOCATOR_CORE_DEFINES_SVH

// Check a same-cycle implication, skipped while reset is asserted.
`define BBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bba: same-cycle check failed");

// Check an implication in the following cycle, skipped while reset is asserted.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bba: next-cycle check failed");

`endif

// ----- rtl/core/bba_pkg.sv -----
// Shared types, codes and constants of the block ID bump allocator.
package bba_pkg;

    // Default table depth
    localparam int DEF_MAX_BLOCKS = 1024;

    // Register reset values
    localparam logic [31:0] HEAP_START_RST = 32'h0000_0000;
    localparam logic [31:0] HEAP_END_RST   = 32'hFFFF_FFFF;
    localparam logic [9:0]  FIRST_ID_RST   = 10'd0;

    // Register indexes (byte address divided by four)
    localparam logic [1:0] REG_HEAP_START = 2'd0;
    localparam logic [1:0] REG_HEAP_END   = 2'd1;
    localparam logic [1:0] REG_FIRST_ID   = 2'd2;

    // Operation codes
    localparam logic [1:0] OP_AUTO = 2'd0;
    localparam logic [1:0] OP_AT   = 2'd1;
    localparam logic [1:0] OP_LOOK = 2'd2;
    localparam logic [1:0] OP_BAD  = 2'd3;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_REFUSED = 3'd1,
        ST_NO_ID   = 3'd2,
        ST_NO_MEM  = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK
    } state_t;

    // Configuration write strobe
    typedef struct packed {
        logic        en;
        logic [1:0]  idx;
        logic [31:0] data;
    } cfg_wr_t;

    // Controller to datapath
    typedef struct packed {
        logic    accept;
        logic    clr_wr;
        logic    scan_inc;
        logic    finish;
        logic    alloc_wr;
        status_t status;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       clr_last;
        logic       scan_end;
        logic       entry_valid;
        logic       id_oor;
        logic       bump_ok;
        logic       out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/block_id_bump_allocator_core.sv -----
// Top level of the block ID bump allocator: stream ports, register port, controller and datapath.
//
//  Port group   Role      Payload
//  s_*          request   op, alloc_size, block_id
//  m_*          result    address, assigned_id, status
//  p*           config    heap_start, heap_end, first_block_id at 0x0, 0x4, 0x8
//
// One request is worked at a time: a beat is taken in the idle state and its
// result is decided in the check state from a single table read for a lookup or a
// given-ID allocation. Automatic allocation steps past each taken entry it meets,
// one valid-bit table read a cycle. After reset a clearing pass over all MAX_BLOCKS
// entries zeroes the valid bits; requests wait, register writes are taken. A
// result waits in the output register; the decision holds while it is not taken.
`include "block_id_bump_allocator_core_defines.svh"

module block_id_bump_allocator_core
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // alloc_size[31:0], block_id[43:32], zero [47:44]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // address[31:0], assigned_id[43:32], zero [47:44]
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ctrl_cmd_t   cmd;
    dp_stat_t    stat;
    cfg_wr_t     cfg_wr;
    logic [31:0] out_address;
    logic [11:0] out_id;
    status_t     out_status;

    // Register port: always ready, write on the access phase
    assign pready      = 1'b1;
    assign cfg_wr.en   = psel && penable && pwrite;
    assign cfg_wr.idx  = paddr[3:2];
    assign cfg_wr.data = pwdata;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_op       (s_tuser),
        .in_size     (s_tdata[31:0]),
        .in_id       (s_tdata[43:32]),
        .cfg_wr      (cfg_wr),
        .cfg_rd_idx  (paddr[3:2]),
        .cfg_rd_data (prdata),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_address (out_address),
        .out_id      (out_id),
        .out_status  (out_status)
    );

    // Pack the result beat
    assign m_tdata = {4'd0, out_id, out_address};
    assign m_tuser = out_status;

    // One request at a time: no new beat in the cycle after one is taken
    `BBA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // A decision never overwrites a result that is still waiting
    `BBA_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.finish, stat.out_free)
    // No free ID reports ID zero and address zero
    `BBA_ASSERT_NOW(a_no_id_zero, clk, rst_n, m_tvalid && (m_tuser == ST_NO_ID),
                    (m_tdata[43:32] == 12'd0) && (m_tdata[31:0] == 32'd0))

endmodule

// ----- rtl/core/bba_ctrl.sv -----
// Controller state machine: clearing pass, accept, table check and result decision.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.status   = ST_OK;
        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the valid bits to zero, one entry a cycle
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                case (stat.op)
                    OP_AUTO:
                    begin
                        if (stat.scan_end)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_NO_ID;
                        end
                        else if (stat.entry_valid)
                        begin
                            // Entry taken: advance the scan
                            cmd.scan_inc = 1'b1;
                        end
                        else if (!stat.bump_ok)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_NO_MEM;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_OK;
                        end
                    end
                    OP_AT:
                    begin
                        cmd.finish = 1'b1;
                        if (stat.id_oor)
                        begin
                            cmd.status = ST_RANGE;
                        end
                        else if (stat.entry_valid)
                        begin
                            cmd.status = ST_REFUSED;
                        end
                        else if (!stat.bump_ok)
                        begin
                            cmd.status = ST_NO_MEM;
                        end
                        else
                        begin
                            cmd.status = ST_OK;
                        end
                    end
                    OP_LOOK:
                    begin
                        cmd.finish = 1'b1;
                        if (stat.id_oor)
                        begin
                            cmd.status = ST_RANGE;
                        end
                        else if (stat.entry_valid)
                        begin
                            cmd.status = ST_OK;
                        end
                        else
                        begin
                            cmd.status = ST_REFUSED;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_REFUSED;
                    end
                endcase
                // Hold the decision until the output register can take it
                if (cmd.finish)
                begin
                    if (stat.out_free)
                    begin
                        cmd.alloc_wr = (cmd.status == ST_OK) && (stat.op != OP_LOOK);
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.finish = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/bba_datapath.sv -----
// Datapath: registers, block table memories, scan counter, bump adder and output register.
module bba_datapath
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  in_op,
    input  logic [31:0] in_size,
    input  logic [11:0] in_id,
    input  cfg_wr_t     cfg_wr,
    input  logic [1:0]  cfg_rd_idx,
    output logic [31:0] cfg_rd_data,
    input  ctrl_cmd_t   cmd,
    output dp_stat_t    stat,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [31:0] out_address,
    output logic [11:0] out_id,
    output status_t     out_status
);

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = ((IDX_W > 10) ? IDX_W : 10) + 1;
    localparam int IDC_W  = ((IDX_W + 1) > 12) ? (IDX_W + 1) : 12;
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_BLOCKS - 1);
    localparam logic [IDC_W-1:0] IDC_MAX  = IDC_W'(MAX_BLOCKS);

    // Configuration and allocator state
    logic [31:0]      heap_start_reg;
    logic [31:0]      heap_end_reg;
    logic [9:0]       first_id_reg;
    logic [31:0]      fp_reg;
    logic [CNT_W-1:0] hint_reg;

    // Request and scan
    logic [1:0]       req_op_reg;
    logic [31:0]      req_size_reg;
    logic [11:0]      req_id_reg;
    logic             id_oor_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Table memories and their read data
    logic             valid_mem [MAX_BLOCKS];
    logic [31:0]      start_mem [MAX_BLOCKS];
    logic             rd_valid_reg;
    logic [31:0]      rd_start_reg;

    // Output register
    logic             out_valid_reg;
    logic [31:0]      out_addr_reg;
    logic [11:0]      out_id_reg;
    status_t          out_status_reg;

    logic [IDC_W-1:0] id_ext;
    logic             in_oor;
    logic [CNT_W-1:0] acc_addr;
    logic             rd_en;
    logic [CNT_W-1:0] rd_addr;
    logic [32:0]      bump_sum;
    logic             v_wr_en;
    logic             v_wr_data;
    logic [31:0]      res_addr;
    logic [11:0]      res_id;

    // Decode the incoming beat's table address
    assign id_ext   = IDC_W'(in_id);
    assign in_oor   = id_ext >= IDC_MAX;
    assign acc_addr = (in_op == OP_AUTO) ? hint_reg : CNT_W'(id_ext);

    // Pick the table read: first entry on accept, next entry on a scan step
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = acc_addr;
        if (cmd.accept)
        begin
            rd_en = (in_op == OP_AUTO) ? (acc_addr < CNT_MAX) : !in_oor;
        end
        else if (cmd.scan_inc)
        begin
            rd_addr = cnt_reg + CNT_W'(1);
            rd_en   = rd_addr < CNT_MAX;
        end
    end

    // Scan and clear counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.accept)
        begin
            cnt_next = acc_addr;
        end
        else if (cmd.scan_inc || cmd.clr_wr)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // Bump of the free pointer, checked against the heap end with carry
    assign bump_sum = {1'b0, fp_reg} + {1'b0, req_size_reg};

    assign v_wr_en   = cmd.clr_wr || cmd.alloc_wr;
    assign v_wr_data = cmd.alloc_wr;

    // Valid-bit table
    always_ff @(posedge clk)
    begin
        if (v_wr_en)
        begin
            valid_mem[cnt_reg[IDX_W-1:0]] <= v_wr_data;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[rd_addr[IDX_W-1:0]];
        end
    end

    // Block start table
    always_ff @(posedge clk)
    begin
        if (cmd.alloc_wr)
        begin
            start_mem[cnt_reg[IDX_W-1:0]] <= fp_reg;
        end
        if (rd_en)
        begin
            rd_start_reg <= start_mem[rd_addr[IDX_W-1:0]];
        end
    end

    // Configuration registers, free pointer and search hint
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_start_reg <= HEAP_START_RST;
            heap_end_reg   <= HEAP_END_RST;
            first_id_reg   <= FIRST_ID_RST;
            fp_reg         <= HEAP_START_RST;
            hint_reg       <= CNT_W'(FIRST_ID_RST);
        end
        else if (cfg_wr.en)
        begin
            case (cfg_wr.idx)
                REG_HEAP_START:
                begin
                    heap_start_reg <= cfg_wr.data;
                    fp_reg         <= cfg_wr.data;
                end
                REG_HEAP_END:
                begin
                    heap_end_reg <= cfg_wr.data;
                end
                REG_FIRST_ID:
                begin
                    first_id_reg <= cfg_wr.data[9:0];
                    hint_reg     <= CNT_W'(cfg_wr.data[9:0]);
                end
                default:
                begin
                    heap_end_reg <= heap_end_reg;
                end
            endcase
        end
        else if (cmd.alloc_wr)
        begin
            fp_reg <= bump_sum[31:0];
            if (req_op_reg == OP_AUTO)
            begin
                hint_reg <= cnt_reg;
            end
        end
    end

    // Register readback
    always_comb
    begin
        case (cfg_rd_idx)
            REG_HEAP_START: cfg_rd_data = heap_start_reg;
            REG_HEAP_END:   cfg_rd_data = heap_end_reg;
            REG_FIRST_ID:   cfg_rd_data = {22'd0, first_id_reg};
            default:        cfg_rd_data = 32'd0;
        endcase
    end

    // Counter is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Latch the request beat
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_op_reg   <= in_op;
            req_size_reg <= in_size;
            req_id_reg   <= in_id;
            id_oor_reg   <= in_oor;
        end
    end

    // Result payload
    always_comb
    begin
        res_addr = 32'd0;
        if (cmd.status == ST_OK)
        begin
            res_addr = (req_op_reg == OP_LOOK) ? rd_start_reg : fp_reg;
        end
        case (req_op_reg)
            OP_AUTO: res_id = (cmd.status == ST_NO_ID) ? 12'd0 : 12'(cnt_reg);
            OP_BAD:  res_id = 12'd0;
            default: res_id = req_id_reg;
        endcase
    end

    // Output register: load on finish, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_addr_reg   <= res_addr;
            out_id_reg     <= res_id;
            out_status_reg <= cmd.status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_address = out_addr_reg;
    assign out_id      = out_id_reg;
    assign out_status  = out_status_reg;

    // Status toward the controller
    assign stat.op          = req_op_reg;
    assign stat.clr_last    = cnt_reg == CNT_LAST;
    assign stat.scan_end    = cnt_reg >= CNT_MAX;
    assign stat.entry_valid = rd_valid_reg;
    assign stat.id_oor      = id_oor_reg;
    assign stat.bump_ok     = bump_sum <= {1'b0, heap_end_reg};
    assign stat.out_free    = !out_valid_reg || out_ready;

endmodule
